>>> rtl/assert_macros.svh
// Assertion helpers for the checked frame receiver.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain invariant, checked on every rising edge outside reset.
`define CFR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Implication into the next cycle.
`define CFR_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);

`endif

>>> rtl/cfr_pkg.sv
// Shared types and constants for the checked frame receiver.
// No dependencies; imported by cfr_ctrl, cfr_out and checked_frame_receiver.
`timescale 1ns / 1ps

package cfr_pkg;

  localparam int unsigned MaxPayloadBytes = 16;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned PosW     = 6;
  localparam int unsigned PayLenW  = 7;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned InTdataW  = 8;
  localparam int unsigned OutTdataW = 16;

  localparam logic [ByteW-1:0]   HeadReset   = 8'hA5;
  localparam logic [ByteW-1:0]   TailReset   = 8'h5A;
  localparam logic [PayLenW-1:0] PayLenReset = 7'd16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HEAD   = 2'd0,
    CFG_TAIL   = 2'd1,
    CFG_PAYLEN = 2'd2
  } cfr_cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_EMIT
  } cfr_state_e;

  // read of one payload byte issued by the sequencer
  typedef struct packed {
    logic            issue;
    logic [PosW-1:0] pos;
    logic            last;
  } cfr_emit_t;

  // back-pressure from the output stage
  typedef struct packed {
    logic ready;
    logic pending;
  } cfr_drain_t;

endpackage

>>> rtl/cfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module cfr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/cfr_ctrl.sv
// Window sequencer: ring pointer and fill count, frame check pass, payload readout.
// Depends on cfr_pkg and assert_macros.svh; drives the window RAM and the output stage.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cfr_ctrl import cfr_pkg::*; #(
  parameter int unsigned MaxPayloadBytes = cfr_pkg::MaxPayloadBytes,
  localparam int unsigned WinDepth = MaxPayloadBytes + 3,
  localparam int unsigned AddrW    = $clog2(WinDepth),
  localparam int unsigned FillW    = $clog2(WinDepth + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [ByteW-1:0]    head_i,
  input  logic [ByteW-1:0]    tail_i,
  input  logic [PayLenW-1:0]  paylen_i,
  input  logic                s_tvalid_i,
  input  logic [ByteW-1:0]    s_byte_i,
  output logic                s_tready_o,
  output logic                ram_we_o,
  output logic [AddrW-1:0]    ram_waddr_o,
  output logic [ByteW-1:0]    ram_wdata_o,
  output logic                ram_re_o,
  output logic [AddrW-1:0]    ram_raddr_o,
  input  logic [ByteW-1:0]    ram_rdata_i,
  output cfr_emit_t           emit_o,
  input  cfr_drain_t          drain_i
);

  cfr_state_e state_q, state_d;
  logic [AddrW-1:0] wp_q, wp_d;
  logic [AddrW-1:0] base_q, base_d;
  logic [AddrW-1:0] cnt_q, cnt_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [ByteW-1:0] sum_q, sum_d;
  logic             ok_q, ok_d;

  logic [AddrW-1:0] pay_eff;
  logic [FillW-1:0] win_len;
  logic [FillW-1:0] keep_fill;
  logic [FillW-1:0] new_fill;
  logic             accept;
  logic             full_hit;
  logic             chk_done;
  logic             chk_pass;
  logic             emit_done;

  // length clamp: zero counts as one, oversize saturates to the built size
  always_comb begin
    if (paylen_i == '0) begin
      pay_eff = AddrW'(1);
    end else if (paylen_i > PayLenW'(MaxPayloadBytes)) begin
      pay_eff = AddrW'(MaxPayloadBytes);
    end else begin
      pay_eff = AddrW'(paylen_i);
    end
  end

  assign win_len   = FillW'(pay_eff) + FillW'(3);
  assign keep_fill = (fill_q >= win_len) ? (win_len - FillW'(1)) : fill_q;
  assign new_fill  = keep_fill + FillW'(1);
  assign accept    = s_tvalid_i && s_tready_o;
  // tail is the incoming byte itself, so it is checked before the pass
  assign full_hit  = (new_fill == win_len) && (s_byte_i == tail_i);
  // pass reads positions 0 .. p+1; data for position k lands at cnt = k+1
  assign chk_done  = (state_q == ST_CHECK) && (cnt_q == pay_eff + AddrW'(2));
  assign chk_pass  = ok_q && (ram_rdata_i == sum_q);
  assign emit_done = (state_q == ST_EMIT) && (cnt_q == pay_eff) && !drain_i.pending;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && full_hit) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (chk_done) begin
          state_d = chk_pass ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (emit_done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_tready_o  = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = wp_q;
    ram_wdata_o = s_byte_i;
    ram_re_o    = 1'b0;
    ram_raddr_o = base_q + cnt_q;
    emit_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        ram_we_o   = s_tvalid_i;
      end
      ST_CHECK: begin
        ram_re_o = (cnt_q <= pay_eff + AddrW'(1));
      end
      ST_EMIT: begin
        ram_raddr_o  = base_q + cnt_q + AddrW'(1);
        emit_o.issue = (cnt_q < pay_eff) && drain_i.ready;
        emit_o.pos   = PosW'(cnt_q);
        emit_o.last  = (cnt_q + AddrW'(1) == pay_eff);
        ram_re_o     = emit_o.issue;
      end
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    wp_d   = wp_q;
    base_d = base_q;
    cnt_d  = cnt_q;
    fill_d = fill_q;
    sum_d  = sum_q;
    ok_d   = ok_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          wp_d = wp_q + AddrW'(1);
          if (new_fill == win_len && !full_hit) begin
            fill_d = win_len - FillW'(1);
          end else begin
            fill_d = new_fill;
          end
          base_d = wp_q - AddrW'(win_len - FillW'(1));
          cnt_d  = '0;
          sum_d  = '0;
          ok_d   = 1'b1;
        end
      end
      ST_CHECK: begin
        cnt_d = cnt_q + AddrW'(1);
        if (cnt_q == AddrW'(1)) begin
          ok_d = ok_q && (ram_rdata_i == head_i);
        end else if (cnt_q >= AddrW'(2) && cnt_q <= pay_eff + AddrW'(1)) begin
          sum_d = sum_q + ram_rdata_i;
        end
        if (chk_done) begin
          cnt_d  = '0;
          fill_d = chk_pass ? '0 : (win_len - FillW'(1));
        end
      end
      ST_EMIT: begin
        if (emit_o.issue) begin
          cnt_d = cnt_q + AddrW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wp_q    <= '0;
      fill_q  <= '0;
      cnt_q   <= '0;
      ok_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      wp_q    <= wp_d;
      fill_q  <= fill_d;
      cnt_q   <= cnt_d;
      ok_q    <= ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    sum_q  <= sum_d;
  end

  `CFR_ASSERT(a_fill_bound, clk_i, rst_ni, fill_q <= FillW'(WinDepth), "window fill overrun")
  `CFR_ASSERT(a_no_read_idle, clk_i, rst_ni, !(s_tready_o && ram_re_o), "RAM read while taking input")
  `CFR_ASSERT(a_emit_empty, clk_i, rst_ni, (state_q != ST_EMIT) || (fill_q == '0), "window not emptied on match")
  `CFR_ASSERT_NEXT(a_issue_pend, clk_i, rst_ni, emit_o.issue, drain_i.pending, "issued read not tracked")

endmodule

>>> rtl/cfr_out.sv
// Output stage: catches RAM read data and holds one word for the master side.
// Depends on cfr_pkg; fed by cfr_ctrl and the window RAM.
`timescale 1ns / 1ps

module cfr_out import cfr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfr_emit_t            emit_i,
  input  logic [ByteW-1:0]     rdata_i,
  output cfr_drain_t           drain_o,
  output logic                 m_tvalid_o,
  input  logic                 m_tready_i,
  output logic [OutTdataW-1:0] m_tdata_o,
  output logic                 m_tlast_o
);

  localparam int unsigned PadW = OutTdataW - PosW - ByteW;

  logic            pend_q, pend_d;
  logic [PosW-1:0] pend_pos_q;
  logic            pend_last_q;
  logic            out_vld_q, out_vld_d;
  logic [ByteW-1:0] out_byte_q;
  logic [PosW-1:0] out_pos_q;
  logic            out_last_q;
  logic            load;

  // RAM holds its read data until the next read, so pending data waits there
  assign load = pend_q && (!out_vld_q || m_tready_i);

  assign drain_o.ready   = !pend_q || load;
  assign drain_o.pending = pend_q;

  always_comb begin
    pend_d = pend_q;
    if (emit_i.issue) begin
      pend_d = 1'b1;
    end else if (load) begin
      pend_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (load) begin
      out_vld_d = 1'b1;
    end else if (m_tready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      pend_q    <= pend_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_i.issue) begin
      pend_pos_q  <= emit_i.pos;
      pend_last_q <= emit_i.last;
    end
    if (load) begin
      out_byte_q <= rdata_i;
      out_pos_q  <= pend_pos_q;
      out_last_q <= pend_last_q;
    end
  end

  assign m_tvalid_o = out_vld_q;
  assign m_tdata_o  = {PadW'(0), out_pos_q, out_byte_q};
  assign m_tlast_o  = out_last_q;

endmodule

>>> rtl/checked_frame_receiver.sv
// A byte that does not complete a window with the tail value is written to the window RAM, and input stays ready.
// A byte that does runs a check pass over the window RAM through its one read port.
// On a match the payload is read out at one word per cycle while the output does not stall.
// The first payload word passes the RAM read register and the output register; output holds one word.
// Reset: asynchronous, clears the window (fill count, pointer) and restores the
// registers to head 0xA5, tail 0x5A, payload length 16; the RAM is not cleared.
`timescale 1ns / 1ps

module checked_frame_receiver import cfr_pkg::*; #(
  parameter int unsigned MaxPayloadBytes = cfr_pkg::MaxPayloadBytes
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_wdata_i,
  input  logic                 s_tvalid_i,
  output logic                 s_tready_o,
  input  logic [InTdataW-1:0]  s_tdata_i,   // [7:0] rx_byte
  output logic                 m_tvalid_o,
  input  logic                 m_tready_i,
  output logic [OutTdataW-1:0] m_tdata_o,   // [7:0] payload_byte, [13:8] byte_position
  output logic                 m_tlast_o    // last_byte
);

  localparam int unsigned WinDepth = MaxPayloadBytes + 3;
  localparam int unsigned AddrW    = $clog2(WinDepth);
  localparam int unsigned MemDepth = 1 << AddrW;

  logic [ByteW-1:0]   head_q;
  logic [ByteW-1:0]   tail_q;
  logic [PayLenW-1:0] paylen_q;

  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [ByteW-1:0] ram_wdata;
  logic             ram_re;
  logic [AddrW-1:0] ram_raddr;
  logic [ByteW-1:0] ram_rdata;
  cfr_emit_t        emit;
  cfr_drain_t       drain;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= HeadReset;
      tail_q   <= TailReset;
      paylen_q <= PayLenReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HEAD:   head_q   <= cfg_wdata_i;
        CFG_TAIL:   tail_q   <= cfg_wdata_i;
        CFG_PAYLEN: paylen_q <= cfg_wdata_i[PayLenW-1:0];
        default: ;
      endcase
    end
  end

  cfr_ctrl #(
    .MaxPayloadBytes(MaxPayloadBytes)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_q),
    .tail_i      (tail_q),
    .paylen_i    (paylen_q),
    .s_tvalid_i  (s_tvalid_i),
    .s_byte_i    (s_tdata_i[ByteW-1:0]),
    .s_tready_o  (s_tready_o),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .emit_o      (emit),
    .drain_i     (drain)
  );

  cfr_ram #(
    .Width(ByteW),
    .Depth(MemDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  cfr_out u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .emit_i     (emit),
    .rdata_i    (ram_rdata),
    .drain_o    (drain),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tlast_o  (m_tlast_o)
  );

endmodule

>>> verif/checked_frame_receiver_test.sv
// Self-checking testbench for checked_frame_receiver: streams received bytes in,
// predicts the deframed payload words and compares each one as it comes out.
// Depends on rtl/cfr_pkg.sv and rtl/checked_frame_receiver.sv.
`timescale 1ns / 1ps

module checked_frame_receiver_test;
  import cfr_pkg::*;

  localparam int unsigned WindowDepth    = MaxPayloadBytes + 3;
  localparam int unsigned SettleCycles   = 40;
  localparam int unsigned LongHoldCycles = 300;
  localparam int unsigned MaxGap         = 17;
  localparam int unsigned RandomWords    = 250;
  localparam int unsigned PhaseWords     = 35;
  localparam int unsigned RunLimitNs     = 4_000_000;
  // index past the register list; the block must ignore it
  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 2'd3;

  typedef enum int unsigned {
    FRAME_CLEAN,
    FRAME_BAD_HEAD,
    FRAME_BAD_SUM,
    FRAME_BAD_TAIL,
    FRAME_CUT
  } frame_flaw_e;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic [PosW-1:0]  pos;
    logic             last;
  } payload_word_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i   = '0;
  logic [CfgDataW-1:0]  cfg_wdata_i = '0;
  logic                 s_tvalid_i  = 1'b0;
  logic                 s_tready_o;
  logic [InTdataW-1:0]  s_tdata_i   = '0;  // [7:0] rx_byte
  logic                 m_tvalid_o;
  logic                 m_tready_i  = 1'b0;
  logic [OutTdataW-1:0] m_tdata_o;         // [7:0] payload_byte, [13:8] byte_position
  logic                 m_tlast_o;         // last_byte

  checked_frame_receiver dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tlast_o  (m_tlast_o)
  );

  // register shadows
  logic [ByteW-1:0]   head_cfg = HeadReset;
  logic [ByteW-1:0]   tail_cfg = TailReset;
  logic [PayLenW-1:0] len_cfg  = PayLenReset;

  // window shadow, oldest byte at index 0
  logic [ByteW-1:0] window_q [WindowDepth];
  int unsigned      window_count = 0;

  logic [ByteW-1:0] rx_backlog[$];
  payload_word_t    payload_words_due[$];

  bit          sender_gaps_on     = 1'b0;
  bit          receiver_stalls_on = 1'b0;
  int unsigned hold_requests      = 0;
  int unsigned fault_count        = 0;
  int unsigned bytes_taken        = 0;
  int unsigned words_checked      = 0;
  int unsigned frames_matched     = 0;
  int unsigned queued_words       = 0;
  int unsigned settings_used      = 1;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned active_payload();
    if (len_cfg == 0) return 1;
    if (len_cfg > MaxPayloadBytes) return MaxPayloadBytes;
    return len_cfg;
  endfunction

  task automatic drop_held(input int unsigned n);
    if (n >= window_count) begin
      window_count = 0;
    end else begin
      for (int unsigned k = 0; k + n < window_count; k++) window_q[k] = window_q[k + n];
      window_count -= n;
    end
  endtask

  // Frame search over the sliding window; queues the payload words of a match.
  task automatic track_rx_byte(input logic [ByteW-1:0] rx);
    int unsigned      p;
    int unsigned      span;
    logic [ByteW-1:0] sum;
    payload_word_t    w;
    p = active_payload();
    span = p + 3;
    // a lowered length keeps only the newest bytes that still fit
    if (window_count >= span) drop_held(window_count - (span - 1));
    if (window_count >= WindowDepth) drop_held(1);
    window_q[window_count] = rx;
    window_count++;
    if (window_count != span) return;
    sum = '0;
    for (int unsigned k = 1; k <= p; k++) sum += window_q[k];
    if (window_q[0] == head_cfg && window_q[p + 2] == tail_cfg && window_q[p + 1] == sum) begin
      for (int unsigned k = 0; k < p; k++) begin
        w.data = window_q[k + 1];
        w.pos  = PosW'(k);
        w.last = (k + 1 == p);
        payload_words_due.push_back(w);
      end
      window_count = 0;
      frames_matched++;
    end else begin
      drop_held(1);
    end
  endtask

  // sender
  always @(posedge clk_i or negedge rst_ni) begin : rx_sender
    int unsigned send_wait;
    if (!rst_ni) begin
      s_tvalid_i <= 1'b0;
      s_tdata_i  <= '0;
      send_wait  = 0;
    end else if (!s_tvalid_i || s_tready_o) begin
      if (send_wait != 0) begin
        send_wait--;
        s_tvalid_i <= 1'b0;
      end else if (rx_backlog.size() != 0) begin
        s_tdata_i  <= rx_backlog.pop_front();
        s_tvalid_i <= 1'b1;
        send_wait  = sender_gaps_on ? $urandom_range(0, MaxGap) : 0;
      end else begin
        s_tvalid_i <= 1'b0;
      end
    end
  end

  // receiver; a long hold is counted here when the stimulus asks for one
  always @(posedge clk_i or negedge rst_ni) begin : tx_receiver
    int unsigned stall_left;
    int unsigned hold_left;
    int unsigned holds_served;
    int unsigned pause;
    if (!rst_ni) begin
      m_tready_i   <= 1'b0;
      stall_left   = 0;
      hold_left    = 0;
      holds_served = 0;
    end else if (holds_served != hold_requests) begin
      holds_served++;
      hold_left = LongHoldCycles;
      m_tready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      m_tready_i <= 1'b0;
    end else if (m_tvalid_o && m_tready_i) begin
      pause = receiver_stalls_on ? $urandom_range(0, MaxGap) : 0;
      stall_left = pause;
      m_tready_i <= (pause == 0);
    end else if (stall_left != 0) begin
      stall_left--;
      m_tready_i <= (stall_left == 0);
    end else begin
      m_tready_i <= 1'b1;
    end
  end

  // monitor: check outgoing words first, then predict from the incoming word
  always @(posedge clk_i) begin : watch
    payload_word_t due;
    if (rst_ni) begin
      if (m_tvalid_o && m_tready_i) begin
        words_checked++;
        if (payload_words_due.size() == 0) begin
          $error("payload word %0h with none expected", m_tdata_o);
          fault_count++;
        end else begin
          due = payload_words_due.pop_front();
          if (m_tdata_o[7:0] !== due.data) begin
            $error("payload_byte: expected %0h, got %0h", due.data, m_tdata_o[7:0]);
            fault_count++;
          end
          if (m_tdata_o[13:8] !== due.pos) begin
            $error("byte_position: expected %0d, got %0d", due.pos, m_tdata_o[13:8]);
            fault_count++;
          end
          if (m_tlast_o !== due.last) begin
            $error("last_byte: expected %0b, got %0b", due.last, m_tlast_o);
            fault_count++;
          end
        end
      end
      if (s_tvalid_i && s_tready_o) begin
        bytes_taken++;
        track_rx_byte(s_tdata_i[7:0]);
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_HEAD:   head_cfg = value;
      CFG_TAIL:   tail_cfg = value;
      CFG_PAYLEN: len_cfg  = value[PayLenW-1:0];
      default: ;
    endcase
  endtask

  task automatic push_rx(input logic [ByteW-1:0] b);
    rx_backlog.push_back(b);
    queued_words++;
  endtask

  task automatic queue_noise(input int unsigned n);
    repeat (n) push_rx(ByteW'($urandom_range(0, 255)));
  endtask

  task automatic queue_frame(input frame_flaw_e flaw);
    logic [ByteW-1:0] frame_q[$];
    logic [ByteW-1:0] sum;
    logic [ByteW-1:0] b;
    int unsigned      p;
    p = active_payload();
    sum = '0;
    frame_q.push_back(head_cfg);
    for (int unsigned k = 0; k < p; k++) begin
      b = ByteW'($urandom_range(0, 255));
      frame_q.push_back(b);
      sum += b;
    end
    frame_q.push_back(sum);
    frame_q.push_back(tail_cfg);
    case (flaw)
      FRAME_BAD_HEAD: frame_q[0]     ^= ByteW'($urandom_range(1, 255));
      FRAME_BAD_SUM:  frame_q[p + 1] ^= ByteW'($urandom_range(1, 255));
      FRAME_BAD_TAIL: frame_q[p + 2] ^= ByteW'($urandom_range(1, 255));
      FRAME_CUT:      void'(frame_q.pop_back());
      default: ;
    endcase
    foreach (frame_q[k]) push_rx(frame_q[k]);
  endtask

  // waits until all queued bytes are sent and all due words are out, then gives the block time to settle
  task automatic wait_until_quiet();
    while (rx_backlog.size() != 0 || s_tvalid_i || payload_words_due.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic [ByteW-1:0] pick_marker(input logic [ByteW-1:0] usual);
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hFF;
      2: return usual;
      default: return ByteW'($urandom_range(0, 255));
    endcase
  endfunction

  // cycles through zero, saturating values and bit 7 of the write data; mostly small
  function automatic logic [CfgDataW-1:0] pick_length(input int unsigned n);
    case (n % 12)
      0: return 8'h01;
      1: return 8'h03;
      2: return 8'h7F;
      3: return 8'h02;
      4: return 8'h00;
      5: return 8'h05;
      6: return 8'hC0;
      7: return 8'h04;
      8: return 8'h10;
      9: return 8'h02;
      10: return 8'h08;
      default: return CfgDataW'($urandom_range(1, 6));
    endcase
  endfunction

  initial begin : stimulus
    int unsigned random_words;
    int unsigned phase_start;
    int unsigned phase_idx;
    int unsigned roll;
    int unsigned mode;
    random_words = 0;
    phase_idx = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // out-of-range index must not touch any register
    write_reg(CfgIdxUnused, 8'h00);
    for (int unsigned k = 0; k < MaxPayloadBytes; k++) begin
      if (k == 0) push_rx(HeadReset);
      push_rx((k % 2 == 0) ? 8'h00 : 8'hFF);
    end
    push_rx(8'(MaxPayloadBytes / 2 * 8'hFF));
    push_rx(TailReset);
    wait_until_quiet();

    // zero length acts as one payload byte
    write_reg(CFG_PAYLEN, 8'h00);
    settings_used++;
    push_rx(HeadReset);
    push_rx(8'hFF);
    push_rx(8'hFF);
    push_rx(TailReset);
    queue_frame(FRAME_BAD_SUM);
    wait_until_quiet();

    // leave bytes in the window, then shrink the frame under them
    write_reg(CFG_PAYLEN, 8'h10);
    queue_noise(9);
    wait_until_quiet();
    write_reg(CFG_PAYLEN, 8'h02);
    settings_used++;
    queue_frame(FRAME_CLEAN);
    wait_until_quiet();

    while (random_words < RandomWords) begin
      write_reg(CFG_HEAD, pick_marker(HeadReset));
      write_reg(CFG_TAIL, pick_marker(TailReset));
      write_reg(CFG_PAYLEN, pick_length(phase_idx));
      settings_used++;
      mode = $urandom_range(0, 3);
      sender_gaps_on     = mode[0];
      receiver_stalls_on = mode[1];
      phase_start = queued_words;
      while (queued_words - phase_start < PhaseWords) begin
        roll = $urandom_range(0, 99);
        if (roll < 70) queue_frame(FRAME_CLEAN);
        else if (roll < 85) queue_frame(frame_flaw_e'($urandom_range(1, 4)));
        else queue_noise($urandom_range(1, 5));
        if ($urandom_range(0, 19) == 0) wait_until_quiet();
      end
      random_words += queued_words - phase_start;
      wait_until_quiet();
      phase_idx++;
    end

    // full-size frames against a long output stall: input side must back up
    write_reg(CFG_HEAD, HeadReset);
    write_reg(CFG_TAIL, TailReset);
    write_reg(CFG_PAYLEN, 8'h10);
    settings_used++;
    sender_gaps_on     = 1'b0;
    receiver_stalls_on = 1'b0;
    hold_requests++;
    repeat (4) queue_frame(FRAME_CLEAN);
    wait_until_quiet();

    $display("Covered %0d input words over %0d register settings: %0d frames matched,",
             bytes_taken, settings_used, frames_matched);
    $display("%0d payload words checked, with gaps, stalls and a long output hold.",
             words_checked);
    if (fault_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #(RunLimitNs);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> checked_frame_receiver.f
+incdir+rtl
rtl/cfr_pkg.sv
rtl/cfr_ram.sv
rtl/cfr_ctrl.sv
rtl/cfr_out.sv
rtl/checked_frame_receiver.sv
verif/checked_frame_receiver_test.sv
